>>> rtl/core/dmgn_pkg.sv
// Shared types, widths and constants for the depth map to gray normaliser.
// Used by dmgn_ctrl, dmgn_datapath and the top level; no dependencies.

package dmgn_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W   = 16;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int COEF_W     = 9;
    localparam int PROD_W     = DIFF_W + COEF_W;
    localparam int NUM_W      = PROD_W - 1;
    localparam int DEN_W      = DIFF_W;
    localparam int REM_W      = DEN_W + 1;
    localparam int CNT_W      = $clog2(NUM_W);
    localparam int GRAY_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    // Statistic reset values and gray scale constants
    localparam logic signed [SAMPLE_W-1:0] STAT_MIN_RESET = SAMPLE_W'(2048);
    localparam logic signed [SAMPLE_W-1:0] STAT_MAX_RESET = SAMPLE_W'(0);
    localparam logic signed [SAMPLE_W-1:0] DISP_LIMIT     = SAMPLE_W'(2047);
    localparam logic [GRAY_W-1:0] GRAY_FULL    = 8'd255;
    localparam logic [GRAY_W-1:0] GRAY_BASE    = 8'd64;
    localparam logic [GRAY_W-1:0] GRAY_ZERO    = 8'd0;
    localparam logic [GRAY_W-1:0] SCALE_NORMAL = GRAY_FULL - GRAY_BASE;

    // Sample format codes
    typedef enum logic [1:0] {
        FMT_DISPARITY  = 2'd0,
        FMT_MILLIMETRE = 2'd1,
        FMT_HUNDRED_UM = 2'd2
    } depth_fmt_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEPTH_FORMAT = 1'd0,
        CFG_INVERSE_MODE = 1'd1
    } cfg_idx_t;

    // Input function codes
    typedef enum logic {
        FUNC_GATHER = 1'b0,
        FUNC_MAP    = 1'b1
    } func_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic cap;
        logic gat;
        logic mul;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic bypass;
        logic div_last;
    } dp_stat_t;

endpackage

>>> rtl/core/dmgn_ctrl.sv
// Controller state machine of the depth map to gray normaliser.
// Depends on dmgn_pkg for state, command and status types.

module dmgn_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                func,
    input  logic                out_stall,
    input  dmgn_pkg::dp_stat_t  stat,
    output logic                in_stall,
    output logic                out_valid,
    output dmgn_pkg::ctrl_cmd_t cmd
);

    dmgn_pkg::state_t state_reg;
    dmgn_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    // Output register can take a result when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dmgn_pkg::ST_IDLE:
            begin
                if (in_valid && (func == dmgn_pkg::FUNC_MAP))
                begin
                    state_next = dmgn_pkg::ST_MUL;
                end
            end
            dmgn_pkg::ST_MUL:
            begin
                if (stat.bypass)
                begin
                    state_next = dmgn_pkg::ST_OUT;
                end
                else
                begin
                    state_next = dmgn_pkg::ST_DIV;
                end
            end
            dmgn_pkg::ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = dmgn_pkg::ST_OUT;
                end
            end
            dmgn_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = dmgn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmgn_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        in_stall     = 1'b1;
        cmd          = '0;
        case (state_reg)
            dmgn_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.cap  = in_valid && (func == dmgn_pkg::FUNC_MAP);
                cmd.gat  = in_valid && (func == dmgn_pkg::FUNC_GATHER);
            end
            dmgn_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            dmgn_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            dmgn_pkg::ST_OUT:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Output valid: set on load, drop once the transaction completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmgn_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/dmgn_datapath.sv
// Datapath of the depth map to gray normaliser: configuration, statistics,
// scaling multiplier, bit-serial divider and output register. Uses dmgn_pkg.

module dmgn_datapath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  dmgn_pkg::ctrl_cmd_t                    cmd,
    output dmgn_pkg::dp_stat_t                     stat,
    input  logic                                   cfg_we,
    input  logic [dmgn_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dmgn_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   frame_start,
    input  logic signed [dmgn_pkg::SAMPLE_W-1:0]   depth_sample,
    output logic [dmgn_pkg::GRAY_W-1:0]            gray_level
);

    // Configuration and statistics
    dmgn_pkg::depth_fmt_t                  fmt_reg;
    logic                                  inv_mode_reg;
    logic signed [dmgn_pkg::SAMPLE_W-1:0]  min_reg;
    logic signed [dmgn_pkg::SAMPLE_W-1:0]  min_next;
    logic signed [dmgn_pkg::SAMPLE_W-1:0]  max_reg;
    logic signed [dmgn_pkg::SAMPLE_W-1:0]  max_next;

    // Captured operands
    logic signed [dmgn_pkg::DIFF_W-1:0]    diff_reg;
    logic signed [dmgn_pkg::DIFF_W-1:0]    den_s_reg;
    logic                                  inv_reg;
    logic                                  byp_reg;
    logic [dmgn_pkg::GRAY_W-1:0]           byp_val_reg;

    // Divider
    logic [dmgn_pkg::NUM_W-1:0]            num_reg;
    logic [dmgn_pkg::DEN_W-1:0]            den_reg;
    logic [dmgn_pkg::DEN_W-1:0]            rem_reg;
    logic                                  neg_reg;
    logic [dmgn_pkg::CNT_W-1:0]            cnt_reg;

    logic [dmgn_pkg::GRAY_W-1:0]           gray_reg;

    // Combinational terms
    logic                                  smp_valid;
    logic signed [dmgn_pkg::SAMPLE_W-1:0]  base_min;
    logic signed [dmgn_pkg::SAMPLE_W-1:0]  base_max;
    logic signed [dmgn_pkg::DIFF_W-1:0]    cap_diff;
    logic signed [dmgn_pkg::DIFF_W-1:0]    cap_den;
    logic                                  cap_byp;
    logic [dmgn_pkg::GRAY_W-1:0]           cap_byp_val;
    logic [dmgn_pkg::GRAY_W-1:0]           coef;
    logic signed [dmgn_pkg::PROD_W-1:0]    prod;
    logic [dmgn_pkg::PROD_W-1:0]           prod_mag;
    logic [dmgn_pkg::DIFF_W-1:0]           den_mag;
    logic [dmgn_pkg::REM_W-1:0]            rem_sh;
    logic [dmgn_pkg::REM_W-1:0]            rem_sub;
    logic                                  q_bit;
    logic [dmgn_pkg::GRAY_W-1:0]           q8;
    logic [dmgn_pkg::GRAY_W-1:0]           gray_calc;

    // Validity of the incoming sample under the current format
    always_comb
    begin
        case (fmt_reg)
            dmgn_pkg::FMT_DISPARITY:
            begin
                smp_valid = !depth_sample[dmgn_pkg::SAMPLE_W-1]
                            && (depth_sample < dmgn_pkg::DISP_LIMIT);
            end
            dmgn_pkg::FMT_MILLIMETRE, dmgn_pkg::FMT_HUNDRED_UM:
            begin
                smp_valid = depth_sample > dmgn_pkg::STAT_MAX_RESET;
            end
            default:
            begin
                smp_valid = 1'b0;
            end
        endcase
    end

    // Running minimum and maximum, optionally restarted at frame start
    always_comb
    begin
        base_min = frame_start ? dmgn_pkg::STAT_MIN_RESET : min_reg;
        base_max = frame_start ? dmgn_pkg::STAT_MAX_RESET : max_reg;
        min_next = base_min;
        max_next = base_max;
        if (smp_valid && (depth_sample < base_min))
        begin
            min_next = depth_sample;
        end
        if (smp_valid && (depth_sample > base_max))
        begin
            max_next = depth_sample;
        end
    end

    // Operands and short-cut results for a map sample
    always_comb
    begin
        if (inv_mode_reg)
        begin
            cap_diff    = dmgn_pkg::DIFF_W'(depth_sample);
            cap_den     = dmgn_pkg::DIFF_W'(max_reg);
            cap_byp     = depth_sample[dmgn_pkg::SAMPLE_W-1]
                          || (max_reg == dmgn_pkg::STAT_MAX_RESET);
            cap_byp_val = dmgn_pkg::GRAY_FULL;
        end
        else
        begin
            cap_diff    = dmgn_pkg::DIFF_W'(depth_sample) - dmgn_pkg::DIFF_W'(min_reg);
            cap_den     = dmgn_pkg::DIFF_W'(max_reg) - dmgn_pkg::DIFF_W'(min_reg);
            cap_byp     = !smp_valid || (max_reg == min_reg);
            cap_byp_val = smp_valid ? dmgn_pkg::GRAY_BASE : dmgn_pkg::GRAY_ZERO;
        end
    end

    // Scale the difference, then split into magnitudes and quotient sign
    assign coef     = inv_reg ? dmgn_pkg::GRAY_FULL : dmgn_pkg::SCALE_NORMAL;
    assign prod     = diff_reg * $signed({1'b0, coef});
    assign prod_mag = prod[dmgn_pkg::PROD_W-1] ? dmgn_pkg::PROD_W'(-prod)
                                                : dmgn_pkg::PROD_W'(prod);
    assign den_mag  = den_s_reg[dmgn_pkg::DIFF_W-1] ? dmgn_pkg::DIFF_W'(-den_s_reg)
                                                     : dmgn_pkg::DIFF_W'(den_s_reg);

    // One restoring division step
    assign rem_sh  = {rem_reg, num_reg[dmgn_pkg::NUM_W-1]};
    assign q_bit   = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    // Wrap the quotient to eight bits and form the gray level
    assign q8        = neg_reg ? dmgn_pkg::GRAY_W'(~num_reg[dmgn_pkg::GRAY_W-1:0] + 1'b1)
                               : num_reg[dmgn_pkg::GRAY_W-1:0];
    assign gray_calc = inv_reg ? (dmgn_pkg::GRAY_FULL - q8) : (dmgn_pkg::GRAY_BASE + q8);

    // Configuration and statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg      <= dmgn_pkg::FMT_DISPARITY;
            inv_mode_reg <= 1'b0;
            min_reg      <= dmgn_pkg::STAT_MIN_RESET;
            max_reg      <= dmgn_pkg::STAT_MAX_RESET;
        end
        else
        begin
            if (cfg_we && (cfg_index == dmgn_pkg::CFG_DEPTH_FORMAT))
            begin
                fmt_reg <= dmgn_pkg::depth_fmt_t'(cfg_data);
            end
            if (cfg_we && (cfg_index == dmgn_pkg::CFG_INVERSE_MODE))
            begin
                inv_mode_reg <= cfg_data[0];
            end
            if (cmd.gat)
            begin
                min_reg <= min_next;
                max_reg <= max_next;
            end
        end
    end

    // Operand capture, divider and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            diff_reg    <= cap_diff;
            den_s_reg   <= cap_den;
            inv_reg     <= inv_mode_reg;
            byp_reg     <= cap_byp;
            byp_val_reg <= cap_byp_val;
        end
        if (cmd.mul)
        begin
            num_reg <= prod_mag[dmgn_pkg::NUM_W-1:0];
            den_reg <= den_mag;
            neg_reg <= prod[dmgn_pkg::PROD_W-1] ^ den_s_reg[dmgn_pkg::DIFF_W-1];
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= q_bit ? rem_sub[dmgn_pkg::DEN_W-1:0] : rem_sh[dmgn_pkg::DEN_W-1:0];
            num_reg <= {num_reg[dmgn_pkg::NUM_W-2:0], q_bit};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            gray_reg <= byp_reg ? byp_val_reg : gray_calc;
        end
    end

    assign stat.bypass   = byp_reg;
    assign stat.div_last = cnt_reg == dmgn_pkg::CNT_W'(dmgn_pkg::NUM_W - 1);
    assign gray_level    = gray_reg;

endmodule

>>> rtl/core/depth_map_to_gray_normalizer_unit.sv
// Top level of the depth map to gray normaliser.
// Instantiates dmgn_ctrl and dmgn_datapath; types from dmgn_pkg.

// Each frame is sent twice. A gather transaction (func 0) updates the running
// minimum and maximum of the valid samples and gives no result; frame_start
// restarts the statistics with that sample. A map transaction (func 1)
// yields one gray level and occupies the block while it steps through
// accept, the scaling multiply, the bit-serial divider that produces one
// quotient bit a cycle, and the load of the output register.
// Samples that need no division (invalid, zero range, negative or zero
// maximum in inverse mode) skip the divider. The output register lets the
// next transaction be accepted while a result still waits to be taken.
// Configuration must be written only while the block is idle (not enforced).

module depth_map_to_gray_normalizer_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [dmgn_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dmgn_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   func,
    input  logic                                   frame_start,
    input  logic signed [dmgn_pkg::SAMPLE_W-1:0]   depth_sample,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [dmgn_pkg::GRAY_W-1:0]            gray_level
);

    dmgn_pkg::ctrl_cmd_t cmd;
    dmgn_pkg::dp_stat_t  stat;

    // Sequencing
    dmgn_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .func      (func),
        .out_stall (out_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // Arithmetic and storage
    dmgn_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .frame_start  (frame_start),
        .depth_sample (depth_sample),
        .gray_level   (gray_level)
    );

endmodule
